/* hdl/kfq_pkg.sv */
// Package for the keyed FIFO queue: request and result item types, op and status codes, back part states.
// No dependencies.
package kfq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_REMOVE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] key;
        logic        [31:0] item_data;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] out_key;
        logic        [31:0] out_data;
        logic        [4:0]  length;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_UNLINK,
        S_DONE
    } t_state;

endpackage

/* hdl/kfq_front.sv */
// Front part: two-entry request queue between the input channel and the back part.
// Depends on kfq_pkg.
module kfq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kfq_pkg::t_req  i_req,
    output logic           o_req_valid,
    input  logic           i_req_ready,
    output kfq_pkg::t_req  o_req
);
    kfq_pkg::t_req r_q [2];
    logic [1:0]    r_cnt;
    logic          r_rd;
    logic          w_push;
    logic          w_pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign w_pop       = o_req_valid && i_req_ready;
    assign o_req       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_rd ^ r_cnt[0]] <= i_req;
        end
    end
endmodule

/* hdl/kfq_back.sv */
// Back part: linked list in slot memories, walked one link at a time (read, then check), result register.
// Depends on kfq_pkg.
module kfq_back #(
    parameter int DEPTH     = 16,
    parameter int DATA_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  kfq_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output kfq_pkg::t_rsp  o_rsp
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]          r_keys [DEPTH];
    logic [DATA_BITS-1:0] r_data [DEPTH];
    logic [IW-1:0]        r_link [DEPTH];
    logic [DEPTH-1:0]     r_free;
    logic [IW-1:0]        r_head, r_tail;
    logic [CW-1:0]        r_count;

    kfq_pkg::t_state r_state, n_state;
    kfq_pkg::t_req   r_req;
    logic [IW-1:0]   r_cur, r_prev;
    logic            r_has_prev;
    logic [CW-1:0]   r_steps;
    logic [31:0]     r_rkey;
    logic [DATA_BITS-1:0] r_rdata;
    logic [IW-1:0]   r_rlink;
    logic            r_ovalid;
    kfq_pkg::t_rsp   r_rsp;

    logic [IW-1:0]   w_slot;
    logic [CW-1:0]   w_cnt_dec;
    logic [31:0]     w_odata;

    always_comb begin
        w_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_slot = IW'(i);
            end
        end
    end

    assign w_cnt_dec   = r_count - CW'(1);
    assign o_req_ready = (r_state == kfq_pkg::S_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_rsp       = r_rsp;
    assign w_odata     = 32'(r_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kfq_pkg::S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    if (i_req.op == kfq_pkg::OP_PUSH || r_count == '0) begin
                        n_state = kfq_pkg::S_IDLE;
                    end else begin
                        n_state = kfq_pkg::S_READ;
                    end
                end
            end
            kfq_pkg::S_READ:   n_state = kfq_pkg::S_CHECK;
            kfq_pkg::S_CHECK: begin
                if (r_req.op == kfq_pkg::OP_POP
                        || r_rkey == r_req.key) begin
                    n_state = (r_req.op == kfq_pkg::OP_CONTAINS)
                              ? kfq_pkg::S_IDLE : kfq_pkg::S_UNLINK;
                end else if (r_steps == CW'(1)) begin
                    n_state = kfq_pkg::S_IDLE;
                end else begin
                    n_state = kfq_pkg::S_READ;
                end
            end
            kfq_pkg::S_UNLINK: n_state = kfq_pkg::S_IDLE;
            default:           n_state = kfq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kfq_pkg::S_READ) begin
            r_rkey  <= r_keys[r_cur];
            r_rdata <= r_data[r_cur];
            r_rlink <= r_link[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= '1;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                kfq_pkg::S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        r_req      <= i_req;
                        r_cur      <= r_head;
                        r_has_prev <= 1'b0;
                        r_prev     <= '0;
                        r_steps    <= r_count;
                        r_rsp.out_key  <= '0;
                        r_rsp.out_data <= '0;
                        if (i_req.op == kfq_pkg::OP_PUSH) begin
                            r_ovalid     <= 1'b1;
                            r_rsp.length <= 5'(r_count);
                            if (r_count == CW'(DEPTH)) begin
                                r_rsp.status <= kfq_pkg::ST_FULL;
                            end else begin
                                r_rsp.status <= kfq_pkg::ST_OK;
                                r_rsp.length <= 5'(r_count + CW'(1));
                                r_free[w_slot] <= 1'b0;
                                if (r_count == '0) begin
                                    r_head <= w_slot;
                                end
                                r_tail  <= w_slot;
                                r_count <= r_count + CW'(1);
                            end
                        end else if (r_count == '0) begin
                            r_ovalid     <= 1'b1;
                            r_rsp.status <= kfq_pkg::ST_EMPTY;
                            r_rsp.length <= '0;
                        end
                    end
                end
                kfq_pkg::S_CHECK: begin
                    if (r_req.op == kfq_pkg::OP_POP || r_rkey == r_req.key) begin
                        if (r_req.op == kfq_pkg::OP_CONTAINS) begin
                            r_ovalid     <= 1'b1;
                            r_rsp.status <= kfq_pkg::ST_OK;
                            r_rsp.length <= 5'(r_count);
                        end
                    end else if (r_steps == CW'(1)) begin
                        r_ovalid     <= 1'b1;
                        r_rsp.status <= kfq_pkg::ST_EMPTY;
                        r_rsp.length <= 5'(r_count);
                    end else begin
                        r_prev     <= r_cur;
                        r_has_prev <= 1'b1;
                        r_cur      <= r_rlink;
                        r_steps    <= r_steps - CW'(1);
                    end
                end
                kfq_pkg::S_UNLINK: begin
                    r_ovalid       <= 1'b1;
                    r_rsp.status   <= kfq_pkg::ST_OK;
                    r_rsp.out_key  <= r_rkey;
                    r_rsp.out_data <= w_odata;
                    r_rsp.length   <= 5'(w_cnt_dec);
                    r_free[r_cur]  <= 1'b1;
                    r_count        <= w_cnt_dec;
                    if (!r_has_prev) begin
                        r_head <= r_rlink;
                    end
                    if (r_tail == r_cur) begin
                        r_tail <= r_prev;
                    end
                    if (w_cnt_dec == '0) begin
                        r_head <= '0;
                        r_tail <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kfq_pkg::S_IDLE && i_req_valid && o_req_ready
                && i_req.op == kfq_pkg::OP_PUSH && r_count != CW'(DEPTH)) begin
            r_keys[w_slot] <= i_req.key;
            r_data[w_slot] <= DATA_BITS'(i_req.item_data);
            if (r_count != '0) begin
                r_link[r_tail] <= w_slot;
            end
        end else if (r_state == kfq_pkg::S_UNLINK && r_has_prev) begin
            r_link[r_prev] <= r_rlink;
        end
    end
endmodule

/* hdl/keyed_fifo_queue.sv */
// Top level of the keyed FIFO queue: front request queue and back list engine.
// Depends on kfq_pkg, kfq_front, kfq_back.
//
// Usage: requests enter on i_valid/o_ready with an i_req item (op, key, item_data);
// results leave on o_valid/i_ready with an o_rsp item (status, out_key, out_data,
// length). Exactly one result per request, in request order.
// The request queue registers each item before the back part takes it.
// Push, and any request on an empty queue, give the result in the cycle after the back
// part takes it. Pop passes through the read, check and unlink states. Contains and
// remove pass the read and check states once per entry visited (one memory read, one
// compare), and a remove then passes the unlink state.
// A two-entry request queue in front keeps accepting while the back part works.
// When the receiver stalls, the result register holds and the back part waits;
// the request queue fills and then drops o_ready.
// Reset (synchronous, active low) empties the queue: all slots free, length zero.
// Stored keys, data and links are undefined until written; no clearing pass.
module keyed_fifo_queue #(
    parameter int DEPTH     = 16,
    parameter int DATA_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kfq_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output kfq_pkg::t_rsp  o_rsp
);
    logic          w_req_valid;
    logic          w_req_ready;
    kfq_pkg::t_req w_req;

    kfq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_req_valid (w_req_valid),
        .i_req_ready (w_req_ready),
        .o_req       (w_req)
    );

    kfq_back #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .o_req_ready (w_req_ready),
        .i_req       (w_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

`ifndef ASSERT_OFF
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.length <= 5'(DEPTH)))
        else $error("length beyond depth");
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == kfq_pkg::ST_FULL) |-> (o_rsp.length == 5'(DEPTH)))
        else $error("full reported below depth");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == kfq_pkg::ST_EMPTY) |-> (o_rsp.out_data == '0))
        else $error("data on empty result");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result lost under stall");
`endif
endmodule

/* tb/kfq_checker.sv */
// Checker for the keyed FIFO queue: watches both channels, predicts each result
// from its own list model and compares. Depends on kfq_pkg.
module kfq_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_ready_in,
    input  kfq_pkg::t_req i_req,
    input  logic          i_out_valid,
    input  logic          i_ready,
    input  kfq_pkg::t_rsp i_rsp,
    output int            o_errors,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    logic [31:0] slot_key [DEPTH];
    logic [31:0] slot_data [DEPTH];
    logic [3:0]  slot_next [DEPTH];
    logic        slot_free [DEPTH];
    logic [3:0]  head_q, tail_q;
    int          count_q;
    kfq_pkg::t_rsp rsp_queue [$];

    initial begin
        o_errors = 0;
        for (int i = 0; i < DEPTH; i++) slot_free[i] = 1'b1;
        head_q = '0;
        tail_q = '0;
        count_q = 0;
    end

    assign o_pending = rsp_queue.size();

    task automatic report(input string what, input logic [70:0] got, input logic [70:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic void free_slot(input logic [3:0] s);
        slot_free[s] = 1'b1;
        count_q--;
        if (count_q == 0) begin
            head_q = '0;
            tail_q = '0;
        end
    endfunction

    function automatic kfq_pkg::t_rsp queue_step(input kfq_pkg::t_req r);
        kfq_pkg::t_rsp o;
        logic [3:0]  cur, prev, s;
        logic        has_prev;
        o = '0;
        if (r.op == kfq_pkg::OP_PUSH) begin
            if (count_q >= DEPTH) begin
                o.status = kfq_pkg::ST_FULL;
            end else begin
                s = '0;
                for (int i = DEPTH - 1; i >= 0; i--) if (slot_free[i]) s = 4'(i);
                slot_free[s] = 1'b0;
                slot_key[s] = r.key;
                slot_data[s] = r.item_data;
                if (count_q == 0) head_q = s;
                else slot_next[tail_q] = s;
                tail_q = s;
                count_q++;
                o.status = kfq_pkg::ST_OK;
            end
        end else if (count_q == 0) begin
            o.status = kfq_pkg::ST_EMPTY;
        end else if (r.op == kfq_pkg::OP_POP) begin
            cur = head_q;
            o.out_key = slot_key[cur];
            o.out_data = slot_data[cur];
            head_q = slot_next[cur];
            free_slot(cur);
            o.status = kfq_pkg::ST_OK;
        end else begin
            o.status = kfq_pkg::ST_EMPTY;
            cur = head_q;
            prev = '0;
            has_prev = 1'b0;
            for (int i = 0; i < count_q; i++) begin
                if (slot_key[cur] == r.key) begin
                    o.status = kfq_pkg::ST_OK;
                    if (r.op == kfq_pkg::OP_REMOVE) begin
                        o.out_key = r.key;
                        o.out_data = slot_data[cur];
                        if (has_prev) slot_next[prev] = slot_next[cur];
                        else head_q = slot_next[cur];
                        if (tail_q == cur) tail_q = prev;
                        free_slot(cur);
                    end
                    break;
                end
                prev = cur;
                has_prev = 1'b1;
                if (i + 1 < count_q) cur = slot_next[cur];
            end
        end
        o.length = count_q[4:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        kfq_pkg::t_rsp want;
        if (i_rst_n && i_valid && i_ready_in) rsp_queue.push_back(queue_step(i_req));
        if (i_rst_n && i_out_valid && i_ready) begin
            if (rsp_queue.size() == 0) begin
                report("unexpected result", i_rsp, '0);
            end else begin
                want = rsp_queue.pop_front();
                if (i_rsp.status !== want.status) report("status", i_rsp.status, want.status);
                if (i_rsp.out_key !== want.out_key) report("out_key", i_rsp.out_key, want.out_key);
                if (i_rsp.out_data !== want.out_data)
                    report("out_data", i_rsp.out_data, want.out_data);
                if (i_rsp.length !== want.length) report("length", i_rsp.length, want.length);
            end
        end
    end
endmodule

/* tb/testbench.sv */
// Top of the keyed FIFO queue testbench: clock, reset, request stimulus, result
// back-pressure and verdict. Depends on kfq_pkg, keyed_fifo_queue, kfq_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic  clk = 0;
    logic  rst_n = 0;
    logic  req_valid = 0;
    logic  req_ready;
    kfq_pkg::t_req req = '0;
    logic  rsp_valid;
    logic  rsp_ready = 0;
    kfq_pkg::t_rsp rsp;
    int    errors, pending;
    bit    quiet = 0;
    logic [31:0] used_keys [$];

    always begin
        #10 clk = 1;
        #10 clk = 0;
    end

    keyed_fifo_queue u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .o_ready(req_ready),
        .i_req(req), .o_valid(rsp_valid), .i_ready(rsp_ready), .o_rsp(rsp)
    );

    kfq_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .i_ready_in(req_ready),
        .i_req(req), .i_out_valid(rsp_valid), .i_ready(rsp_ready), .i_rsp(rsp),
        .o_errors(errors), .o_pending(pending)
    );

    // back-pressure in random bursts
    always @(posedge clk) begin
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clk);
        end
        rsp_ready <= 1'b1;
    end

    task automatic send(input kfq_pkg::t_op op, input logic [31:0] k, input logic [31:0] d);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req.op <= op;
        req.key <= k;
        req.item_data <= d;
        req_valid <= 1'b1;
        if (op == kfq_pkg::OP_PUSH) used_keys.push_back(k);
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if ($urandom_range(0, 1)) return $urandom_range(0, 7);
        return $urandom;
    endfunction

    initial begin
        int c;
        kfq_pkg::t_op op;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // empty queue cases
        send(kfq_pkg::OP_POP, 0, 0);
        send(kfq_pkg::OP_CONTAINS, 32'h8000_0000, 0);
        send(kfq_pkg::OP_REMOVE, 32'h7fff_ffff, 0);
        // fill to full with extreme keys and data
        for (int i = 0; i < 16; i++)
            send(kfq_pkg::OP_PUSH, i[0] ? 32'h8000_0000 + i : 32'h7fff_fff0 + i,
                 i[1] ? 32'hffff_ffff : i);
        send(kfq_pkg::OP_PUSH, 32'hffff_ffff, 32'hffff_ffff);
        send(kfq_pkg::OP_CONTAINS, 32'h7fff_fffe, 0);
        send(kfq_pkg::OP_REMOVE, 32'h7fff_fffe, 0);
        send(kfq_pkg::OP_REMOVE, 32'h8000_0001, 0);
        send(kfq_pkg::OP_REMOVE, 32'h1234_5678, 0);
        send(kfq_pkg::OP_POP, 0, 0);
        for (int i = 0; i < 750; i++) begin
            if (i == 650) quiet = 1;
            c = $urandom_range(0, 9);
            op = c < 4 ? kfq_pkg::OP_PUSH : c < 6 ? kfq_pkg::OP_POP
               : c < 8 ? kfq_pkg::OP_CONTAINS : kfq_pkg::OP_REMOVE;
            send(op, op == kfq_pkg::OP_PUSH
                     ? ($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom)
                     : pick_key(), $urandom);
            if (used_keys.size() > 64) void'(used_keys.pop_front());
        end
        req_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0) $display("keyed_fifo_queue: match");
        else $display("keyed_fifo_queue: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("keyed_fifo_queue: mismatch");
        $finish;
    end
endmodule
